[hdl/base64_stream_decoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit_macros
// assertion helpers used by the top-level decoder file
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64_STREAM_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define B64SD_ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define B64SD_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

[hdl/b64sd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sd_pkg
// types, constants and the character map of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64sd_pkg;

   localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0]  CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0]  CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0]  CHAR_PLUS    = 8'h2B;
   localparam logic [7:0]  CHAR_SLASH   = 8'h2F;
   localparam logic [7:0]  CHAR_PAD     = 8'h3D;

   localparam logic [7:0]  LOWER_OFFSET = 8'd26;
   localparam logic [7:0]  DIGIT_OFFSET = 8'd52;
   localparam logic [5:0]  SEXTET_PLUS  = 6'd62;
   localparam logic [5:0]  SEXTET_SLASH = 6'd63;

   localparam logic [15:0] MAX_BYTES_RESET = 16'd1024;

   localparam logic [1:0]  STATUS_OK         = 2'd0;
   localparam logic [1:0]  STATUS_BAD_LENGTH = 2'd1;
   localparam logic [1:0]  STATUS_INVALID    = 2'd2;

   localparam logic [1:0]  LAST_POSITION = 2'd3;
   localparam logic [1:0]  THIRD_POSITION = 2'd2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        byte_valid;
      logic        end_of_run;
      logic [1:0]  status;
      logic [15:0] decoded_count;
   } rsp_type;

   // result of one accepted character, handed to the output serializer
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      items;
      logic            has_bytes;
      logic            end_of_run;
      logic [1:0]      status;
      logic [15:0]     decoded_count;
   } packet_type;

   // returns {valid, sextet}; pad reads as a valid zero
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [7:0] v;
      logic       ok;
      v  = 8'd0;
      ok = 1'b1;
      case (c) inside
         [CHAR_UPPER_A:CHAR_UPPER_Z]: v = c - CHAR_UPPER_A;
         [CHAR_LOWER_A:CHAR_LOWER_Z]: v = c - CHAR_LOWER_A + LOWER_OFFSET;
         [CHAR_DIGIT_0:CHAR_DIGIT_9]: v = c - CHAR_DIGIT_0 + DIGIT_OFFSET;
         CHAR_PLUS:                   v = {2'b00, SEXTET_PLUS};
         CHAR_SLASH:                  v = {2'b00, SEXTET_SLASH};
         CHAR_PAD:                    v = 8'd0;
         default:                     ok = 1'b0;
      endcase
      return {ok, v[5:0]};
   endfunction

endpackage

[hdl/b64sd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sd_core
// stream state, group decode, truncation and end-of-string report
// ----------------------------------------------------------------------------
module b64sd_core import b64sd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   input  req_type     req_data,
   output logic        req_stall,
   input  logic        pkt_take,
   output logic        pkt_valid,
   output packet_type  pkt_data
);

   logic [15:0]     max_bytes_ff;
   logic [1:0]      pos_ff;
   logic [2:0][5:0] held_ff;
   logic            third_pad_ff;
   logic [15:0]     count_ff;
   logic            invalid_ff;
   logic            stopped_ff;
   logic            pkt_valid_ff;
   packet_type      pkt_ff;

   logic            accept;
   logic [6:0]      lookup;
   logic            char_ok;
   logic [5:0]      sextet;
   logic            pad;
   logic            invalid_in;
   logic            group_done;
   logic            emit_group;
   logic [7:0]      byte0, byte1, byte2;
   logic [1:0]      wanted;
   logic [16:0]     room;
   logic            has_room;
   logic [1:0]      emitted;
   logic [15:0]     count_in;
   logic            stopped_in;
   logic [1:0]      status;
   logic            load;
   packet_type      pkt_in;

   assign req_stall = pkt_valid_ff & ~pkt_take;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      lookup     = sextet_of(req_data.char_code);
      char_ok    = lookup[6];
      pad        = (req_data.char_code == CHAR_PAD) && pos_ff[1];
      sextet     = pad ? 6'd0 : lookup[5:0];
      invalid_in = invalid_ff | (~char_ok & ~stopped_ff);
      group_done = (pos_ff == LAST_POSITION);
      emit_group = group_done & ~stopped_ff & ~invalid_in;

      byte0 = {held_ff[0], held_ff[1][5:4]};
      byte1 = {held_ff[1][3:0], held_ff[2][5:2]};
      byte2 = {held_ff[2][1:0], sextet};

      wanted   = 2'd1 + {1'b0, ~third_pad_ff} + {1'b0, ~pad};
      room     = {1'b0, max_bytes_ff} - {1'b0, count_ff};
      has_room = count_ff < max_bytes_ff;
      if (!emit_group || !has_room) begin
         emitted = 2'd0;
      end else if (room < {15'd0, wanted}) begin
         emitted = room[1:0];
      end else begin
         emitted = wanted;
      end
      count_in   = count_ff + {14'd0, emitted};
      stopped_in = stopped_ff | (emit_group & (count_in >= max_bytes_ff));

      if (!group_done) begin
         status = STATUS_BAD_LENGTH;
      end else if (invalid_in) begin
         status = STATUS_INVALID;
      end else begin
         status = STATUS_OK;
      end

      // wanted bytes in emit order; a pad in the third place skips the middle byte
      pkt_in.bytes[0]      = byte0;
      pkt_in.bytes[1]      = third_pad_ff ? byte2 : byte1;
      pkt_in.bytes[2]      = byte2;
      pkt_in.has_bytes     = (emitted != 2'd0);
      pkt_in.items         = pkt_in.has_bytes ? emitted : 2'd1;
      pkt_in.end_of_run    = req_data.last_char;
      pkt_in.status        = status;
      pkt_in.decoded_count = (status == STATUS_OK) ? count_in : 16'd0;

      load = accept & (pkt_in.has_bytes | req_data.last_char);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_wr_en) begin
         max_bytes_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         third_pad_ff <= 1'b0;
         count_ff     <= 16'd0;
         invalid_ff   <= 1'b0;
         stopped_ff   <= 1'b0;
      end else if (accept) begin
         if (req_data.last_char) begin
            pos_ff       <= 2'd0;
            third_pad_ff <= 1'b0;
            count_ff     <= 16'd0;
            invalid_ff   <= 1'b0;
            stopped_ff   <= 1'b0;
         end else begin
            pos_ff     <= pos_ff + 2'd1;
            count_ff   <= count_in;
            invalid_ff <= invalid_in;
            stopped_ff <= stopped_in;
            if (pos_ff == THIRD_POSITION) begin
               third_pad_ff <= pad;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !group_done) begin
         held_ff[pos_ff] <= sextet;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_valid_ff <= 1'b0;
      end else if (load) begin
         pkt_valid_ff <= 1'b1;
      end else if (pkt_take) begin
         pkt_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pkt_ff <= pkt_in;
      end
   end

   assign pkt_valid = pkt_valid_ff;
   assign pkt_data  = pkt_ff;

endmodule

[hdl/b64sd_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sd_serializer
// sends one character's results as one transaction per cycle unless rsp_stall
// ----------------------------------------------------------------------------
module b64sd_serializer import b64sd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pkt_valid,
   input  packet_type pkt_data,
   output logic       pkt_take,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       rsp_stall
);

   packet_type cur_ff;
   logic [1:0] left_ff;

   logic       out_fire;
   logic       final_item;
   logic       end_item;

   assign rsp_valid  = (left_ff != 2'd0);
   assign out_fire   = rsp_valid & ~rsp_stall;
   assign final_item = (left_ff == 2'd1);
   assign pkt_take   = pkt_valid & (~rsp_valid | (out_fire & final_item));
   assign end_item   = cur_ff.end_of_run & final_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
      end else if (pkt_take) begin
         left_ff <= pkt_data.items;
      end else if (out_fire) begin
         left_ff <= left_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_take) begin
         cur_ff <= pkt_data;
      end else if (out_fire) begin
         cur_ff.bytes <= {8'h00, cur_ff.bytes[2:1]};
      end
   end

   always_comb begin
      rsp_data.data_byte     = cur_ff.has_bytes ? cur_ff.bytes[0] : 8'h00;
      rsp_data.byte_valid    = cur_ff.has_bytes;
      rsp_data.end_of_run    = end_item;
      rsp_data.status        = end_item ? cur_ff.status : STATUS_OK;
      rsp_data.decoded_count = end_item ? cur_ff.decoded_count : 16'd0;
   end

endmodule

[hdl/base64_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// base64 character stream in, decoded bytes and end-of-string status out
//
//   port group   direction  contents
//   req_         in         one character and its last-character flag
//   rsp_         out        one decoded byte, or the end report, per transaction
//   csr_         in         write of the output byte limit
//
// one character is taken per cycle unless req_stall; results go through the
// packet buffer and serializer and leave one per cycle unless rsp_stall.
// a packet buffer sits between decode and serializer; req_stall rises only while
// a packet waits behind a serializer that still has items to send.
// with a stalled result port, the serializer and the packet buffer fill first.
// synchronous reset sets the byte limit to 1024 and clears the stream; no
// clearing pass.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_unit_macros.svh"

module base64_stream_decoder_unit import b64sd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   input  req_type     req_data,
   output logic        req_stall,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        rsp_stall
);

   logic       pkt_valid;
   logic       pkt_take;
   packet_type pkt_data;

   b64sd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .pkt_take    (pkt_take),
      .pkt_valid   (pkt_valid),
      .pkt_data    (pkt_data)
   );

   b64sd_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .pkt_valid (pkt_valid),
      .pkt_data  (pkt_data),
      .pkt_take  (pkt_take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // input only backs up behind a waiting result
   `B64SD_ASSERT_IMPLIES(a_stall_needs_result, clock, reset, req_stall, rsp_valid,
      "input stalled with no result pending")

   // a transaction without a byte is always the end report
   `B64SD_ASSERT_IMPLIES(a_empty_is_end, clock, reset,
      rsp_valid && !rsp_data.byte_valid, rsp_data.end_of_run,
      "byteless transaction is not the end report")

   // failed strings report a zero count
   `B64SD_ASSERT_IMPLIES(a_fail_zero_count, clock, reset,
      rsp_valid && rsp_data.status != STATUS_OK, rsp_data.decoded_count == 16'd0,
      "failed string reports nonzero count")

endmodule

[tb/base64_stream_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit_tb
// self-checking bench for the base64 stream decoder
//
// strings of characters go in one per transaction. A predictor in the bench
// decodes every accepted character and queues the result transactions it
// expects. A monitor compares each result field by field with the oldest
// entry in that queue. The byte limit is changed between phases while the
// decoder is idle. Traffic is well-formed text with random content, broken
// strings and noise. Both sides stall at random.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit_tb;
   import b64sd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   req_type     req_data = '0;
   logic        req_stall;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        rsp_stall = 1'b0;

   base64_stream_decoder_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall)
   );

   always #2 clock = ~clock;

   // stimulus and expectations
   req_type     char_q [$];
   logic [7:0]  text_q [$];
   rsp_type     decoded_q [$];
   rsp_type     want_rsp;
   int          chars_added = 0;
   int          mismatches = 0;

   // predictor state
   logic [15:0] byte_limit = MAX_BYTES_RESET;
   logic [1:0]  grp_pos = '0;
   logic [5:0]  held [0:2];
   logic        third_pad = 1'b0;
   logic [15:0] byte_cnt = '0;
   logic        bad_seen = 1'b0;
   logic        stopped = 1'b0;

   // traffic shaping
   logic        req_taken = 1'b0;
   logic        rsp_hold = 1'b0;
   logic        quiet = 1'b0;
   int          gap_left = 0;
   int          stall_left = 0;

   // {valid, sextet}; '=' reads as a valid zero
   function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return {1'b1, 6'(c - CHAR_UPPER_A)};
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return {1'b1, 6'(c - CHAR_LOWER_A + 8'd26)};
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return {1'b1, 6'(c - CHAR_DIGIT_0 + 8'd52)};
      if (c == CHAR_PLUS) return {1'b1, SEXTET_PLUS};
      if (c == CHAR_SLASH) return {1'b1, SEXTET_SLASH};
      if (c == CHAR_PAD) return 7'b1_000000;
      return 7'b0_000000;
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      if (v < 6'd26) return CHAR_UPPER_A + 8'(v);
      if (v < 6'd52) return CHAR_LOWER_A + 8'(v - 6'd26);
      if (v < 6'd62) return CHAR_DIGIT_0 + 8'(v - 6'd52);
      if (v == SEXTET_PLUS) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   function automatic logic [7:0] random_bad_char();
      logic [7:0] c;
      logic [6:0] look;
      c    = 8'($urandom_range(0, 255));
      look = sextet_lookup(c);
      while (look[6]) begin
         c    = 8'($urandom_range(0, 255));
         look = sextet_lookup(c);
      end
      return c;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic clear_stream();
      grp_pos = '0;
      held[0] = '0;
      held[1] = '0;
      held[2] = '0;
      third_pad = 1'b0;
      byte_cnt = '0;
      bad_seen = 1'b0;
      stopped = 1'b0;
   endtask

   // decode one accepted character and queue the results it causes
   task automatic decode_char(input req_type r);
      logic [6:0] look;
      logic [5:0] v;
      logic [1:0] pos;
      logic       pad;
      logic       halt;
      logic [1:0] st;
      logic [7:0] b [0:2];
      logic       wanted [0:2];
      rsp_type    made [0:2];
      int         n;
      int         i;
      pos  = grp_pos;
      look = sextet_lookup(r.char_code);
      v    = look[5:0];
      pad  = (r.char_code == CHAR_PAD) && (pos >= THIRD_POSITION);
      n    = 0;
      if (pad) v = '0;
      // characters after truncation are not checked
      if (!look[6] && !stopped) bad_seen = 1'b1;
      if (pos != LAST_POSITION) begin
         held[pos] = v;
         if (pos == THIRD_POSITION) third_pad = pad;
         grp_pos = pos + 2'd1;
      end else begin
         grp_pos = '0;
         if (!stopped && !bad_seen) begin
            b[0] = {held[0], held[1][5:4]};
            b[1] = {held[1][3:0], held[2][5:2]};
            b[2] = {held[2][1:0], v};
            wanted[0] = 1'b1;
            wanted[1] = !third_pad;
            wanted[2] = !pad;
            halt = 1'b0;
            for (i = 0; i < 3; i++) begin
               if (wanted[i] && !halt) begin
                  if (byte_cnt >= byte_limit) begin
                     stopped = 1'b1;
                     halt = 1'b1;
                  end else begin
                     made[n] = '0;
                     made[n].data_byte = b[i];
                     made[n].byte_valid = 1'b1;
                     n++;
                     byte_cnt = byte_cnt + 16'd1;
                  end
               end
            end
            if (byte_cnt >= byte_limit) stopped = 1'b1;
         end
      end
      if (r.last_char) begin
         if (pos != LAST_POSITION) st = STATUS_BAD_LENGTH;
         else if (bad_seen) st = STATUS_INVALID;
         else st = STATUS_OK;
         // no byte on the final character: a bare end report
         if (n == 0) begin
            made[0] = '0;
            n = 1;
         end
         made[n-1].end_of_run = 1'b1;
         made[n-1].status = st;
         made[n-1].decoded_count = (st == STATUS_OK) ? byte_cnt : 16'd0;
         clear_stream();
      end
      for (i = 0; i < n; i++)
         decoded_q.push_back(made[i]);
   endtask

   // move the scratch text into the send queue, last character flagged
   task automatic commit_text();
      req_type t;
      int      i;
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
      for (i = 0; i < text_q.size(); i++) begin
         t.char_code = text_q[i];
         t.last_char = (i == text_q.size() - 1);
         char_q.push_back(t);
      end
      chars_added += text_q.size();
      text_q.delete();
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
      commit_text();
   endtask

   // encode nbytes random bytes with standard padding
   task automatic build_text(input int nbytes);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      int         i;
      int         left;
      for (i = 0; i < nbytes; i += 3) begin
         left = nbytes - i;
         b0 = 8'($urandom_range(0, 255));
         b1 = 8'($urandom_range(0, 255));
         b2 = 8'($urandom_range(0, 255));
         text_q.push_back(b64_char(b0[7:2]));
         text_q.push_back(b64_char({b0[1:0], b1[7:4]}));
         text_q.push_back(left > 1 ? b64_char({b1[3:0], b2[7:6]}) : CHAR_PAD);
         text_q.push_back(left > 2 ? b64_char(b2[5:0]) : CHAR_PAD);
      end
   endtask

   task automatic add_random_string();
      int r;
      int n;
      int idx;
      r = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      build_text(n);
      idx = $urandom_range(0, text_q.size() - 1);
      if (r < 70) begin
         // well formed
      end else if (r < 77) begin
         text_q[idx] = random_bad_char();
      end else if (r < 82) begin
         text_q.delete(idx);
      end else if (r < 86) begin
         text_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 93) begin
         text_q[idx] = CHAR_PAD;
      end else begin
         text_q.delete();
         repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      commit_text();
   endtask

   // wait until everything sent has come back, then let the pipe drain
   task automatic settle();
      while (char_q.size() != 0 || req_valid || decoded_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_limit(input logic [15:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      byte_limit = v;
   endtask

   // sender: holds a stalled transaction, otherwise idles or sends the next one
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // payload stays put
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (char_q.size() != 0) begin
         req_data  <= char_q.pop_front();
         req_valid <= 1'b1;
         gap_left = quiet ? 0 : pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (rsp_hold || stall_left != 0) begin
         rsp_stall <= 1'b1;
         if (stall_left != 0) stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = quiet ? 0 : pick_gap();
      end
   end

   // monitor: predict on accepted characters, check accepted results
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) decode_char(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result byte %h valid %b end %b status %0d count %0d",
                           $time, rsp_data.data_byte, rsp_data.byte_valid,
                           rsp_data.end_of_run, rsp_data.status, rsp_data.decoded_count);
            end else begin
               want_rsp = decoded_q.pop_front();
               if (rsp_data.data_byte !== want_rsp.data_byte ||
                   rsp_data.byte_valid !== want_rsp.byte_valid ||
                   rsp_data.end_of_run !== want_rsp.end_of_run ||
                   rsp_data.status !== want_rsp.status ||
                   rsp_data.decoded_count !== want_rsp.decoded_count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%0t: mismatch (expected/actual) byte %h/%h valid %b/%b",
                            $time, want_rsp.data_byte, rsp_data.data_byte,
                            want_rsp.byte_valid, rsp_data.byte_valid);
                     $display(" end %b/%b status %0d/%0d count %0d/%0d",
                              want_rsp.end_of_run, rsp_data.end_of_run,
                              want_rsp.status, rsp_data.status,
                              want_rsp.decoded_count, rsp_data.decoded_count);
                  end
               end
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int phase;
      clear_stream();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed strings at the reset limit
      add_text("AZaz09+/");
      add_text("QU=B");       // pad in third position only
      add_text("=AB=");       // pad in first position, then in fourth
      add_text("QUJ");        // bad length
      text_q.push_back(8'h00);
      text_q.push_back("U");
      text_q.push_back("J");
      text_q.push_back(8'hFF);
      commit_text();          // invalid characters at both code extremes
      settle();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_limit(16'd65535);
            1: set_limit(16'd1);
            2: set_limit(16'd2);
            3: set_limit(16'd3);
            4: set_limit(MAX_BYTES_RESET);
            default: set_limit(16'($urandom_range(1, 40)));
         endcase
         quiet = (phase == 3);
         if (phase == 0) begin
            // long receiver hold while the sender keeps going
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (300) @(posedge clock);
                  rsp_hold = 1'b0;
               end
            join_none
         end
         if (phase == 1) begin
            add_text("QUJD");
            add_text("QUJD!AAA"); // invalid character after truncation
         end
         chars_added = 0;
         while (chars_added < 80) add_random_string();
         settle();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && decoded_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[base64_stream_decoder_unit.f]
+incdir+hdl
hdl/b64sd_pkg.sv
hdl/b64sd_core.sv
hdl/b64sd_serializer.sv
hdl/base64_stream_decoder_unit.sv
tb/base64_stream_decoder_unit_tb.sv
